// File: rtl/dpu_pkg.sv
package dpu_pkg;

   localparam int NUM_CHAN = 4;

   typedef enum logic [2:0] {
      REG_PIXEL_FORMAT = 3'd0,
      REG_RED_MASK     = 3'd1,
      REG_GREEN_MASK   = 3'd2,
      REG_BLUE_MASK    = 3'd3,
      REG_ALPHA_MASK   = 3'd4
   } reg_index_type;

   localparam logic [1:0] FMT_BGR24     = 2'd0;
   localparam logic [1:0] FMT_BGRA32    = 2'd1;
   localparam logic [1:0] FMT_BITFIELDS = 2'd2;

   localparam logic [1:0]  PIXEL_FORMAT_RESET = FMT_BGRA32;
   localparam logic [31:0] RED_MASK_RESET     = 32'h00FF_0000;
   localparam logic [31:0] GREEN_MASK_RESET   = 32'h0000_FF00;
   localparam logic [31:0] BLUE_MASK_RESET    = 32'h0000_00FF;
   localparam logic [31:0] ALPHA_MASK_RESET   = 32'hFF00_0000;

   // mask scan result for one channel
   typedef struct packed {
      logic [31:0] masked;
      logic [4:0]  tz;
      logic [4:0]  msb;
      logic        zero;
   } scan_type;

   // per-channel state through the rounding divider
   typedef struct packed {
      logic        direct;
      logic [7:0]  value;
      logic [14:0] rem;
      logic [14:0] div;
      logic [7:0]  quo;
   } chan_type;

endpackage

// File: rtl/dpu_scan.sv
module dpu_scan (
   input  logic [31:0]       word,
   input  logic [31:0]       mask,
   output dpu_pkg::scan_type scan
);
   import dpu_pkg::*;

   always_comb begin
      scan.masked = word & mask;
      scan.zero   = (mask == 32'd0);
      scan.tz     = '0;
      scan.msb    = '0;
      for (int i = 31; i >= 0; i--) begin
         if (mask[i]) scan.tz = 5'(i);
      end
      for (int i = 0; i < 32; i++) begin
         if (mask[i]) scan.msb = 5'(i);
      end
   end

endmodule

// File: rtl/dpu_align.sv
module dpu_align (
   input  dpu_pkg::scan_type scan,
   input  logic              is_alpha,
   output dpu_pkg::chan_type chan
);
   import dpu_pkg::*;

   logic [4:0]  span;
   logic [2:0]  nbits;
   logic [31:0] shifted;
   logic [31:0] top_shifted;
   logic [6:0]  val;
   logic [6:0]  maxv;

   always_comb begin
      span        = scan.msb - scan.tz;
      nbits       = span[2:0] + 3'd1;
      shifted     = scan.masked >> scan.tz;
      top_shifted = scan.masked >> (scan.msb - 5'd7);
      val         = shifted[6:0];
      maxv        = 7'((8'd1 << nbits) - 8'd1);

      chan.direct = 1'b1;
      chan.value  = 8'd0;
      chan.rem    = '0;
      chan.div    = '0;
      chan.quo    = '0;
      if (scan.zero) begin
         chan.value = is_alpha ? 8'hFF : 8'h00;
      end else if (span >= 5'd7) begin
         chan.value = top_shifted[7:0];
      end else begin
         // round(val * 255 / maxv), quotient bits 7..4 then 3..0
         chan.direct = 1'b0;
         chan.rem    = ({val, 8'd0} - {8'd0, val}) + {9'd0, maxv[6:1]};
         chan.div    = {4'd0, maxv, 4'd0};
      end
   end

endmodule

// File: rtl/dpu_div4.sv
module dpu_div4 (
   input  dpu_pkg::chan_type cin,
   output dpu_pkg::chan_type cout
);
   import dpu_pkg::*;

   logic [17:0] rem;
   logic [17:0] cmp;
   logic [7:0]  quo;

   // four restoring steps; divisor leaves shifted down for the next half
   always_comb begin
      rem = {3'd0, cin.rem};
      quo = cin.quo;
      cmp = '0;
      for (int k = 3; k >= 0; k--) begin
         cmp = {3'd0, cin.div} << k;
         if (rem >= cmp) begin
            rem = rem - cmp;
            quo = {quo[6:0], 1'b1};
         end else begin
            quo = {quo[6:0], 1'b0};
         end
      end
      cout        = cin;
      cout.rem    = rem[14:0];
      cout.quo    = quo;
      cout.div    = cin.div >> 4;
   end

endmodule

// File: rtl/dib_pixel_unpacker.sv
// Bitmap pixel unpacker: one 32-bit pixel word in, 8-bit red/green/blue/alpha out.
// req_*: pixel stream, tdata = pixel_word. rsp_*: result stream, tdata holds
// red, green, blue, alpha from the lowest byte up.
// csr_*: register writes (index 0 format, 1..4 red/green/blue/alpha mask),
// always ready, taken at the edge where csr_valid is high. Write registers
// only while no pixel is in flight.
// Four register stages: mask scan, field alignment, two halves of the
// rounding divider for fields narrower than 8 bits. A taken pixel passes
// through the scan, alignment and both divider registers before rsp_tvalid
// rises; one pixel per cycle sustained while rsp_tready is high, since every
// stage then takes a new pixel each cycle.
// Each stage holds a valid bit and advances when the stage after it is empty
// or moving, so a stalled receiver freezes only the occupied stages and
// bubbles still fill; req_tready drops only when all four stages are full.
// Synchronous reset empties the pipeline and restores the default format
// (32-bit plain) and masks.
module dib_pixel_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dpu_pkg::*;

   logic [1:0]  fmt_ff, fmt_in;
   logic [31:0] mask_ff [NUM_CHAN];
   logic [31:0] mask_in [NUM_CHAN];
   logic [31:0] eff_mask [NUM_CHAN];

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   scan_type s1_in [NUM_CHAN];
   scan_type s1_ff [NUM_CHAN];
   chan_type s2_in [NUM_CHAN];
   chan_type s2_ff [NUM_CHAN];
   chan_type s3_in [NUM_CHAN];
   chan_type s3_ff [NUM_CHAN];
   chan_type s4_dv [NUM_CHAN];
   logic [31:0] s4_in, s4_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      fmt_in = fmt_ff;
      for (int i = 0; i < NUM_CHAN; i++) mask_in[i] = mask_ff[i];
      if (csr_valid) begin
         unique case (csr_index)
            REG_PIXEL_FORMAT: fmt_in     = csr_wdata[1:0];
            REG_RED_MASK:     mask_in[0] = csr_wdata;
            REG_GREEN_MASK:   mask_in[1] = csr_wdata;
            REG_BLUE_MASK:    mask_in[2] = csr_wdata;
            REG_ALPHA_MASK:   mask_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff     <= PIXEL_FORMAT_RESET;
         mask_ff[0] <= RED_MASK_RESET;
         mask_ff[1] <= GREEN_MASK_RESET;
         mask_ff[2] <= BLUE_MASK_RESET;
         mask_ff[3] <= ALPHA_MASK_RESET;
      end else begin
         fmt_ff <= fmt_in;
         for (int i = 0; i < NUM_CHAN; i++) mask_ff[i] <= mask_in[i];
      end
   end

   // fixed formats run through the same path with byte masks
   always_comb begin
      case (fmt_ff)
         FMT_BGR24: begin
            eff_mask[0] = RED_MASK_RESET;
            eff_mask[1] = GREEN_MASK_RESET;
            eff_mask[2] = BLUE_MASK_RESET;
            eff_mask[3] = 32'd0;
         end
         FMT_BITFIELDS: begin
            for (int i = 0; i < NUM_CHAN; i++) eff_mask[i] = mask_ff[i];
         end
         default: begin
            eff_mask[0] = RED_MASK_RESET;
            eff_mask[1] = GREEN_MASK_RESET;
            eff_mask[2] = BLUE_MASK_RESET;
            eff_mask[3] = ALPHA_MASK_RESET;
         end
      endcase
   end

   // stage flow control
   assign en4        = rsp_tready | ~v4_ff;
   assign en3        = en4 | ~v3_ff;
   assign en2        = en3 | ~v2_ff;
   assign en1        = en2 | ~v1_ff;
   assign req_tready = en1;

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      dpu_scan u_scan (
         .word (req_tdata),
         .mask (eff_mask[c]),
         .scan (s1_in[c])
      );
      dpu_align u_align (
         .scan     (s1_ff[c]),
         .is_alpha (c == NUM_CHAN - 1),
         .chan     (s2_in[c])
      );
      dpu_div4 u_div_hi (
         .cin  (s2_ff[c]),
         .cout (s3_in[c])
      );
      dpu_div4 u_div_lo (
         .cin  (s3_ff[c]),
         .cout (s4_dv[c])
      );
      assign s4_in[8*c +: 8] = s4_dv[c].direct ? s4_dv[c].value : s4_dv[c].quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (en1) s1_ff[i] <= s1_in[i];
         if (en2) s2_ff[i] <= s2_in[i];
         if (en3) s3_ff[i] <= s3_in[i];
      end
      if (en4) s4_ff <= s4_in;
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = s4_ff;

   // after the high quotient half the remainder stays below 16 * divisor
   logic [NUM_CHAN-1:0] rem_ok;
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         rem_ok[i] = ~v3_ff | s3_ff[i].direct |
                     ({4'd0, s3_ff[i].rem} < {s3_ff[i].div, 4'd0});
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken with full pipeline");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ok == {NUM_CHAN{1'b1}})
      else $error("divider remainder out of range");

endmodule
